[rtl/deflate_fixed_huffman_token_encoder_macros.svh]
// Assertion macros shared by the fixed-Huffman token encoder RTL.
`ifndef DEFLATE_FIXED_HUFFMAN_TOKEN_ENCODER_MACROS_SVH
`define DEFLATE_FIXED_HUFFMAN_TOKEN_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF
// Condition that must hold at every clock edge outside reset
`define DFH_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
// Consequence that must hold in the cycle after the trigger
`define DFH_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define DFH_ASSERT_ALWAYS(lbl, cond, msg)
`define DFH_ASSERT_NEXT(lbl, trig, cons, msg)
`endif

`endif

[rtl/dfh_pkg.sv]
// Types, code tables and helper functions for the fixed-Huffman token encoder.
package dfh_pkg;

    // Token kinds carried on the input tuser
    typedef enum logic [1:0] {
        CMD_LIT   = 2'd0,
        CMD_MATCH = 2'd1,
        CMD_EOB   = 2'd2,
        CMD_HDR   = 2'd3
    } t_cmd;

    // Variable-length code, already bit-reversed for LSB-first packing
    typedef struct packed {
        logic [8:0] bits;
        logic [3:0] len;
    } t_vlc;

    // Coding result for one token, including the bits carried in
    typedef struct packed {
        logic [39:0] bytes;
        logic [2:0]  nbytes;
        logic [6:0]  pend_bits;
        logic [2:0]  pend_cnt;
    } t_enc_res;

    localparam int LenSyms  = 29;
    localparam int DistSyms = 30;

    localparam logic [8:0] LEN_BASE [LenSyms] = '{
        9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
        9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
        9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
    };
    localparam logic [2:0] LEN_EXTRA [LenSyms] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd0
    };
    localparam logic [15:0] DIST_BASE [DistSyms] = '{
        16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
        16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385, 16'd513,
        16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097, 16'd6145,
        16'd8193, 16'd12289, 16'd16385, 16'd24577
    };
    localparam logic [3:0] DIST_EXTRA [DistSyms] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
        4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
        4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
    };

    // Fixed literal/length code for symbol 0..287, reversed into send order
    function automatic t_vlc litlen_code(input logic [8:0] sym);
        logic [8:0] code;
        logic [8:0] rev;
        logic [3:0] n;
        t_vlc       res;
        if (sym < 9'd144) begin
            code = 9'h030 + sym;
            n    = 4'd8;
        end else if (sym < 9'd256) begin
            code = 9'h190 + (sym - 9'd144);
            n    = 4'd9;
        end else if (sym < 9'd280) begin
            code = sym - 9'd256;
            n    = 4'd7;
        end else begin
            code = 9'h0C0 + (sym - 9'd280);
            n    = 4'd8;
        end
        for (int i = 0; i < 9; i++) begin
            rev[i] = code[8 - i];
        end
        res.bits = rev >> (4'd9 - n);
        res.len  = n;
        return res;
    endfunction

    // 5-bit distance code goes out MSB first
    function automatic logic [4:0] rev5(input logic [4:0] v);
        logic [4:0] r;
        for (int i = 0; i < 5; i++) begin
            r[i] = v[4 - i];
        end
        return r;
    endfunction

endpackage

[rtl/dfh_encoder.sv]
// Token coder: fixed-Huffman codes, extra bits and byte split for one token.
module dfh_encoder (
    input  dfh_pkg::t_cmd     i_cmd,
    input  logic [7:0]        i_lit,
    input  logic [8:0]        i_len,
    input  logic [15:0]       i_dist,
    input  logic              i_final,
    input  logic [6:0]        i_pend_bits,
    input  logic [2:0]        i_pend_cnt,
    output dfh_pkg::t_enc_res o_res
);
    import dfh_pkg::*;

    logic [8:0]  len_c;
    logic [4:0]  len_idx;
    logic [4:0]  len_xv;
    logic [2:0]  len_xn;
    logic [15:0] dist_c;
    logic [4:0]  dist_idx;
    logic [12:0] dist_xv;
    logic [3:0]  dist_xn;
    t_vlc        vlc;
    logic [30:0] tok;
    logic [4:0]  tok_len;
    logic [39:0] acc;
    logic [5:0]  total;
    logic [39:0] rem;

    // Length: saturate, pick symbol by priority compare, extra value
    always_comb begin
        if (i_len < 9'd3) begin
            len_c = 9'd3;
        end else if (i_len > 9'd258) begin
            len_c = 9'd258;
        end else begin
            len_c = i_len;
        end
        len_idx = '0;
        for (int i = 0; i < LenSyms; i++) begin
            if (len_c >= LEN_BASE[i]) begin
                len_idx = 5'(i);
            end
        end
        len_xv = 5'(len_c - LEN_BASE[len_idx]);
        len_xn = LEN_EXTRA[len_idx];
    end

    // Distance: saturate, pick code, extra value
    always_comb begin
        if (i_dist == 16'd0) begin
            dist_c = 16'd1;
        end else if (i_dist > 16'd32768) begin
            dist_c = 16'd32768;
        end else begin
            dist_c = i_dist;
        end
        dist_idx = '0;
        for (int i = 0; i < DistSyms; i++) begin
            if (dist_c >= DIST_BASE[i]) begin
                dist_idx = 5'(i);
            end
        end
        dist_xv = 13'(dist_c - DIST_BASE[dist_idx]);
        dist_xn = DIST_EXTRA[dist_idx];
    end

    // Token bits in send order, LSB first
    always_comb begin
        vlc = litlen_code(9'd256);
        case (i_cmd)
            CMD_LIT: begin
                vlc     = litlen_code({1'b0, i_lit});
                tok     = 31'(vlc.bits);
                tok_len = 5'(vlc.len);
            end
            CMD_MATCH: begin
                vlc     = litlen_code(9'(9'd257 + 9'(len_idx)));
                tok     = 31'(vlc.bits)
                        | (31'(len_xv) << vlc.len)
                        | (31'(rev5(dist_idx)) << (5'(vlc.len) + 5'(len_xn)))
                        | (31'(dist_xv) << (5'(vlc.len) + 5'(len_xn) + 5'd5));
                tok_len = 5'(vlc.len) + 5'(len_xn) + 5'd5 + 5'(dist_xn);
            end
            CMD_EOB: begin
                tok     = 31'(vlc.bits);
                tok_len = 5'(vlc.len);
            end
            CMD_HDR: begin
                tok     = {28'd0, 1'b0, 1'b1, i_final};
                tok_len = 5'd3;
            end
            default: begin
                tok     = '0;
                tok_len = '0;
            end
        endcase
    end

    // Join with carried bits, pad final end of block, split into bytes
    always_comb begin
        acc   = (40'(tok) << i_pend_cnt) | 40'(i_pend_bits);
        total = 6'(i_pend_cnt) + 6'(tok_len);
        if (i_cmd == CMD_EOB && i_final && total[2:0] != 3'd0) begin
            total = {3'(total[5:3] + 3'd1), 3'd0};
        end
        rem             = acc >> {total[5:3], 3'd0};
        o_res.bytes     = acc;
        o_res.nbytes    = total[5:3];
        o_res.pend_bits = rem[6:0];
        o_res.pend_cnt  = total[2:0];
    end

endmodule

[rtl/deflate_fixed_huffman_token_encoder.sv]
// Top level: DEFLATE fixed-Huffman token encoder with stream ports.
// Takes one LZ77 token per request (literal, match, end of block, block
// header), codes it with the fixed literal/length and distance tables and
// sends every completed byte of the bit stream, LSB-first packed, one byte per
// cycle while the output is ready, with tlast on the last byte a token
// completes. Tokens that finish no byte produce nothing. A token registers at
// the input and is coded into the byte buffer register; a new token is taken
// each cycle as long as the buffer drains, so throughput is one token per cycle
// for tokens that yield at most one byte and is bound by the byte output
// otherwise (up to four bytes for a long-distance match). With final_block set,
// end of block pads the last partial byte with zeros; otherwise leftover bits
// carry into the next block. Write final_block only while no token is in flight.
module deflate_fixed_huffman_token_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write: final_block
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    // Token input
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // literal_byte[7:0], match_length[16:8],
                                          // match_distance[32:17], zero fill
    input  logic [1:0]  i_s_axis_tuser,   // cmd[1:0]
    // Byte output
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // out_byte[7:0]
    output logic        o_m_axis_tlast    // last_of_run
);
    `include "deflate_fixed_huffman_token_encoder_macros.svh"
    import dfh_pkg::*;

    logic        r_final;
    logic        r_in_vld;
    t_cmd        r_in_cmd;
    logic [7:0]  r_in_lit;
    logic [8:0]  r_in_len;
    logic [15:0] r_in_dist;
    logic [6:0]  r_pend_bits;
    logic [2:0]  r_pend_cnt;
    logic [39:0] r_buf;
    logic [2:0]  r_cnt;
    t_enc_res    enc;
    logic        w_load;
    logic        w_take;
    logic        w_in_acc;

    // Handshakes
    assign w_take          = o_m_axis_tvalid && i_m_axis_tready;
    assign w_load          = r_in_vld && (r_cnt == 3'd0 || (r_cnt == 3'd1 && i_m_axis_tready));
    assign o_s_axis_tready = !r_in_vld || w_load;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // Byte outputs from the head of the buffer
    assign o_m_axis_tvalid = (r_cnt != 3'd0);
    assign o_m_axis_tdata  = r_buf[7:0];
    assign o_m_axis_tlast  = (r_cnt == 3'd1);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_final <= 1'b0;
        end else if (i_cfg_valid) begin
            r_final <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_cmd  <= t_cmd'(i_s_axis_tuser);
            r_in_lit  <= i_s_axis_tdata[7:0];
            r_in_len  <= i_s_axis_tdata[16:8];
            r_in_dist <= i_s_axis_tdata[32:17];
        end
    end

    // Token coder
    dfh_encoder u_enc (
        .i_cmd       (r_in_cmd),
        .i_lit       (r_in_lit),
        .i_len       (r_in_len),
        .i_dist      (r_in_dist),
        .i_final     (r_final),
        .i_pend_bits (r_pend_bits),
        .i_pend_cnt  (r_pend_cnt),
        .o_res       (enc)
    );

    // Carried bits and byte buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_cnt       <= '0;
        end else if (w_load) begin
            r_pend_bits <= enc.pend_bits;
            r_pend_cnt  <= enc.pend_cnt;
            r_cnt       <= enc.nbytes;
        end else if (w_take) begin
            r_cnt       <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_buf <= enc.bytes;
        end else if (w_take) begin
            r_buf <= r_buf >> 8;
        end
    end

    // Checks
    `DFH_ASSERT_ALWAYS(a_cnt_max, r_cnt <= 3'd4, "byte buffer count above four")
    `DFH_ASSERT_NEXT(a_final_eob_flush, w_load && r_in_cmd == CMD_EOB && r_final, r_pend_cnt == 3'd0, "final end of block left bits pending")
    `DFH_ASSERT_NEXT(a_drain_step, w_take && r_cnt > 3'd1, r_cnt == 3'($past(r_cnt) - 3'd1), "byte buffer did not drain by one")
    `DFH_ASSERT_ALWAYS(a_load_when_free, !w_load || r_cnt <= 3'd1, "token coded over unsent bytes")

endmodule
